>>> sv/fixed_point_alu_q24_8_defines.svh
// Assertion macros for the fixed-point ALU.
// Taken in by the top level; they expect clk and arst_n in scope.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpa: next-cycle check failed");

`endif

>>> sv/fpa_pkg.sv
// Shared types, constants and helper functions of the fixed-point ALU.
// No dependencies; every other file of the block but the assertion macro header uses it.
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int OP_W          = 32;  // width of the operand and result fields
	localparam int XW            = 64;  // internal width of sign-extended operands
	localparam int FRAC_BITS_DEF = 8;
	localparam int WIDTH_DEF     = 32;
	localparam int DIV_STEP      = 4;   // quotient bits retired per divider stage

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_GT       = 4'd4,
		CMD_LT       = 4'd5,
		CMD_GE       = 4'd6,
		CMD_LE       = 4'd7,
		CMD_EQ       = 4'd8,
		CMD_NE       = 4'd9,
		CMD_MIN      = 4'd10,
		CMD_MAX      = 4'd11,
		CMD_INC      = 4'd12,
		CMD_DEC      = 4'd13,
		CMD_FROM_INT = 4'd14,
		CMD_TO_INT   = 4'd15
	} cmd_t;

	typedef struct packed {
		logic [3:0]             command;
		logic signed [OP_W-1:0] operand_a;
		logic signed [OP_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [OP_W-1:0] result_value;
		logic                   compare_true;
		logic                   divide_by_zero;
	} rsp_t;

	// Divider result: low bits of the quotient magnitude plus sign and error flags.
	typedef struct packed {
		logic [OP_W-1:0] q_mag;
		logic            negate;
		logic            by_zero;
	} div_res_t;

	// Number of divider stages for a dividend of OP_W + fb magnitude bits.
	function automatic int div_stages(input int fb);
		return (OP_W + fb + DIV_STEP - 1) / DIV_STEP;
	endfunction

	// Keep the low w bits and sign-extend from bit w-1.
	function automatic logic [XW-1:0] wrap64(input logic [XW-1:0] x, input int w);
		logic [XW-1:0] r;
		for (int i = 0; i < XW; i++) begin
			r[i] = (i < w) ? x[i] : x[w-1];
		end
		return r;
	endfunction

	// Wrap to w bits, then keep the low OP_W bits for the result field.
	function automatic logic [OP_W-1:0] fit32(input logic [XW-1:0] x, input int w);
		logic [XW-1:0] r;
		r = wrap64(x, w);
		return r[OP_W-1:0];
	endfunction

endpackage

>>> sv/fpa_ifs.sv
// Valid/ready channel interfaces for the fixed-point ALU request and response.
// Depends on fpa_pkg for the payload types.
`timescale 1ns / 1ps

interface fpa_req_if;
	logic          valid;
	logic          ready;
	fpa_pkg::req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface fpa_rsp_if;
	logic          valid;
	logic          ready;
	fpa_pkg::rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> sv/fpa_mult.sv
// Two-stage fixed-point multiplier built from 32x32 partial products.
// Depends on fpa_pkg; stage enables come from the top-level pipeline control.
`timescale 1ns / 1ps

module fpa_mult #(
	parameter int WIDTH     = fpa_pkg::WIDTH_DEF,
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic [1:0]               en,
	input  logic [fpa_pkg::XW-1:0]   a,
	input  logic [fpa_pkg::XW-1:0]   b,
	output logic [fpa_pkg::OP_W-1:0] product
);

	localparam int HW = fpa_pkg::XW / 2;

	logic [fpa_pkg::XW-1:0] pp_ll_s2;
	logic [HW-1:0]          pp_hl_s2;
	logic [HW-1:0]          pp_lh_s2;
	logic [fpa_pkg::OP_W-1:0] prod_s3;

	logic [fpa_pkg::XW-1:0]        full_c;
	logic signed [fpa_pkg::XW-1:0] shifted_c;

	// Only the low 64 bits of the product matter, so the high-by-high term drops out
	// and the cross terms are needed modulo 2^32.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp_ll_s2 <= a[HW-1:0] * b[HW-1:0];
			pp_hl_s2 <= a[fpa_pkg::XW-1:HW] * b[HW-1:0];
			pp_lh_s2 <= a[HW-1:0] * b[fpa_pkg::XW-1:HW];
		end
	end

	always_comb begin
		full_c    = pp_ll_s2 + {HW'(pp_hl_s2 + pp_lh_s2), {HW{1'b0}}};
		shifted_c = $signed(full_c) >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s3 <= fpa_pkg::fit32(shifted_c, WIDTH);
		end
	end

	assign product = prod_s3;

endmodule

>>> sv/fpa_div.sv
// Pipelined restoring divider for the fixed-point divide command.
// Depends on fpa_pkg; one preparation stage, then DIV_STEP quotient bits a stage.
`timescale 1ns / 1ps

module fpa_div #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
	parameter int STAGES    = fpa_pkg::div_stages(FRAC_BITS)
) (
	input  logic                   clk,
	input  logic [STAGES:0]        en,
	input  logic [fpa_pkg::XW-1:0] a,
	input  logic [fpa_pkg::XW-1:0] b,
	output fpa_pkg::div_res_t      res
);

	localparam int NUM_W = STAGES * fpa_pkg::DIV_STEP;
	localparam int OW    = fpa_pkg::OP_W;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [OW-1:0]    rem;
		logic [OW-1:0]    quo;
		logic [OW-1:0]    den;
		logic             negate;
		logic             by_zero;
	} div_state_t;

	div_state_t div_s [0:STAGES];

	logic [OW:0]      a_lo;
	logic [OW:0]      b_lo;
	logic [OW:0]      mag_a;
	logic [OW:0]      mag_b;
	logic [NUM_W-1:0] num_init;

	// Both operands fit in OW signed bits at WIDTH up to OW, so their magnitudes fit in OW bits.
	always_comb begin
		a_lo     = a[OW:0];
		b_lo     = b[OW:0];
		mag_a    = a_lo[OW] ? (~a_lo + 1'b1) : a_lo;
		mag_b    = b_lo[OW] ? (~b_lo + 1'b1) : b_lo;
		num_init = NUM_W'(mag_a[OW-1:0]);
		num_init = num_init << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			div_s[0].num     <= num_init;
			div_s[0].rem     <= '0;
			div_s[0].quo     <= '0;
			div_s[0].den     <= mag_b[OW-1:0];
			div_s[0].negate  <= a[fpa_pkg::XW-1] ^ b[fpa_pkg::XW-1];
			div_s[0].by_zero <= (b == '0);
		end
	end

	for (genvar i = 1; i <= STAGES; i++) begin : g_stage
		div_state_t nxt;
		logic [OW:0] trial;

		always_comb begin
			nxt   = div_s[i-1];
			trial = '0;
			for (int j = 0; j < fpa_pkg::DIV_STEP; j++) begin
				trial   = {nxt.rem, nxt.num[NUM_W-1]};
				nxt.num = nxt.num << 1;
				if (trial >= {1'b0, nxt.den}) begin
					nxt.rem = OW'(trial - {1'b0, nxt.den});
					nxt.quo = {nxt.quo[OW-2:0], 1'b1};
				end else begin
					nxt.rem = trial[OW-1:0];
					nxt.quo = {nxt.quo[OW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				div_s[i] <= nxt;
			end
		end
	end

	assign res = '{q_mag: div_s[STAGES].quo,
	               negate: div_s[STAGES].negate,
	               by_zero: div_s[STAGES].by_zero};

endmodule

>>> sv/fixed_point_alu_q24_8.sv
// Fixed-point ALU with signed operands of FRAC_BITS fraction bits: one result beat
// for every request beat, in order. The block is a single pipeline of
// 3 + ceil((32 + FRAC_BITS) / 4) register stages; that depth is set by the divider,
// which retires four quotient bits per stage. A new request beat is taken in every
// cycle while the response side keeps up, and bubbles close up during a stall, so
// the block keeps taking requests while a finished result waits until every stage
// holds an item. All commands share the same latency. Add, subtract, increment,
// decrement, int-to-fixed and fixed-to-int wrap at WIDTH bits; multiply and divide
// wrap the same way after the fraction shift, and a divide by zero returns zero with
// divide_by_zero set. There are no configuration registers and no kept state.
// Depends on fpa_pkg, fpa_ifs, fpa_mult, fpa_div and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_point_alu_q24_8_defines.svh"

module fixed_point_alu_q24_8 #(
	parameter int WIDTH     = fpa_pkg::WIDTH_DEF,
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fpa_req_if.sink    op,
	fpa_rsp_if.source  res
);

	// Stage map: 1 takes the request and wraps the operands, 2 evaluates the simple
	// commands and starts the multiplier and divider, 3 to LAT-1 run the divider
	// (the multiplier finishes in stage 3), and LAT picks and registers the result.
	localparam int DIV_STAGES = fpa_pkg::div_stages(FRAC_BITS);
	localparam int LAT        = DIV_STAGES + 3;
	localparam int OW         = fpa_pkg::OP_W;
	localparam int XW         = fpa_pkg::XW;

	typedef struct packed {
		fpa_pkg::cmd_t cmd;
		logic [OW-1:0] result;
		logic          compare;
	} side_t;

	// Stage enables. A stage loads when it is empty or when the stage after it moves,
	// which lets bubbles close up while the response side is stalled.
	logic [LAT:1] en;
	logic [LAT:1] valid_s;

	fpa_pkg::cmd_t cmd_s1;
	logic [XW-1:0] a_s1;
	logic [XW-1:0] b_s1;

	side_t             side_nxt;
	side_t             side_s [2:LAT-1];
	logic [OW-1:0]     mul_out;
	logic [OW-1:0]     mul_s [4:LAT-1];
	fpa_pkg::div_res_t div_out;
	fpa_pkg::rsp_t     rsp_nxt;
	fpa_pkg::rsp_t     rsp_s;

	always_comb begin
		en[LAT] = !valid_s[LAT] || res.ready;
		for (int k = LAT - 1; k >= 1; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	assign op.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= op.valid;
			end
			for (int k = 2; k <= LAT; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// Stage 1: operands are sign-extended from 32 bits and wrapped to WIDTH bits.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s1 <= fpa_pkg::cmd_t'(op.payload.command);
			a_s1   <= fpa_pkg::wrap64({{(XW - OW){op.payload.operand_a[OW-1]}},
			                           op.payload.operand_a}, WIDTH);
			b_s1   <= fpa_pkg::wrap64({{(XW - OW){op.payload.operand_b[OW-1]}},
			                           op.payload.operand_b}, WIDTH);
		end
	end

	// Stage 2: every command that needs no multiplier or divider finishes here.
	// Comparisons leave the result at zero; min and max pick operand_b on a tie.
	always_comb begin
		logic signed [XW-1:0] sa;
		logic signed [XW-1:0] sb;
		logic [XW-1:0]        raw;
		logic                 cmp;

		sa  = a_s1;
		sb  = b_s1;
		raw = '0;
		cmp = 1'b0;
		unique case (cmd_s1) inside
			fpa_pkg::CMD_ADD:      raw = sa + sb;
			fpa_pkg::CMD_SUB:      raw = sa - sb;
			fpa_pkg::CMD_GT:       cmp = (sa > sb);
			fpa_pkg::CMD_LT:       cmp = (sa < sb);
			fpa_pkg::CMD_GE:       cmp = (sa >= sb);
			fpa_pkg::CMD_LE:       cmp = (sa <= sb);
			fpa_pkg::CMD_EQ:       cmp = (sa == sb);
			fpa_pkg::CMD_NE:       cmp = (sa != sb);
			fpa_pkg::CMD_MIN:      raw = (sa < sb) ? sa : sb;
			fpa_pkg::CMD_MAX:      raw = (sa > sb) ? sa : sb;
			fpa_pkg::CMD_INC:      raw = sa + 1'b1;
			fpa_pkg::CMD_DEC:      raw = sa - 1'b1;
			fpa_pkg::CMD_FROM_INT: raw = sa << FRAC_BITS;
			fpa_pkg::CMD_TO_INT:   raw = sa >>> FRAC_BITS;
			fpa_pkg::CMD_MUL, fpa_pkg::CMD_DIV: raw = '0;
			default:               raw = '0;
		endcase
		side_nxt.cmd     = cmd_s1;
		side_nxt.result  = fpa_pkg::fit32(raw, WIDTH);
		side_nxt.compare = cmp;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s[2] <= side_nxt;
		end
		for (int k = 3; k <= LAT - 1; k++) begin
			if (en[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// The multiplier occupies stages 2 and 3; its result then rides along with the rest.
	fpa_mult #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_mult (
		.clk     (clk),
		.en      (en[3:2]),
		.a       (a_s1),
		.b       (b_s1),
		.product (mul_out)
	);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mul_s[4] <= mul_out;
		end
		for (int k = 5; k <= LAT - 1; k++) begin
			if (en[k]) begin
				mul_s[k] <= mul_s[k-1];
			end
		end
	end

	// The divider occupies stages 2 through LAT-1.
	fpa_div #(
		.FRAC_BITS (FRAC_BITS),
		.STAGES    (DIV_STAGES)
	) u_div (
		.clk (clk),
		.en  (en[LAT-1:2]),
		.a   (a_s1),
		.b   (b_s1),
		.res (div_out)
	);

	// Final stage: apply the quotient sign, wrap it, and select by command.
	always_comb begin
		logic [OW-1:0] q_signed;

		q_signed = div_out.negate ? (~div_out.q_mag + 1'b1) : div_out.q_mag;
		rsp_nxt.compare_true   = side_s[LAT-1].compare;
		rsp_nxt.divide_by_zero = 1'b0;
		unique case (side_s[LAT-1].cmd)
			fpa_pkg::CMD_MUL: begin
				rsp_nxt.result_value = mul_s[LAT-1];
			end
			fpa_pkg::CMD_DIV: begin
				rsp_nxt.divide_by_zero = div_out.by_zero;
				rsp_nxt.result_value   = div_out.by_zero ? '0 :
				                         fpa_pkg::fit32({{(XW - OW){1'b0}}, q_signed}, WIDTH);
			end
			default: begin
				rsp_nxt.result_value = side_s[LAT-1].result;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[LAT]) begin
			rsp_s <= rsp_nxt;
		end
	end

	assign res.valid   = valid_s[LAT];
	assign res.payload = rsp_s;

	// A divide-by-zero beat carries a zero result and no comparison outcome.
	`FPA_ASSERT_NOW(a_dz_zero, res.valid && res.payload.divide_by_zero,
		res.payload.result_value == '0 && !res.payload.compare_true)
	// A true comparison never comes with a nonzero result.
	`FPA_ASSERT_NOW(a_cmp_zero, res.valid && res.payload.compare_true,
		res.payload.result_value == '0)
	// When the response side takes beats, the enable chain must open the input.
	`FPA_ASSERT_NOW(a_ready_chain, res.ready, op.ready)
	// An accepted request beat occupies the first stage in the next cycle.
	`FPA_ASSERT_NEXT(a_enter, op.valid && op.ready, valid_s[1])

endmodule
